// File: rtl/bas_pkg.sv
// ----------------------------------------------------------------------------
// Band antenna selector package
// Shared widths, command and register codes, the band table entry layout and
// the sequencer state type.
// ----------------------------------------------------------------------------
package bas_pkg;

   localparam int FREQ_W      = 32;
   localparam int RELAY_W     = 5;
   localparam int PORT_W      = 4;
   localparam int MASK_BITS   = 8;
   localparam int BAND_W      = 4;
   localparam int KIND_W      = 2;
   localparam int BANDS_CFG_W = 5;
   localparam int PORTS_CFG_W = 4;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 8;

   localparam logic [KIND_W-1:0] KIND_FREQ  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RELAY = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_AUTO_MODE     = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BANDS_IN_USE  = 4'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PORTS_IN_USE  = 4'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SINGLE_A_MODE = 4'd3;

   typedef struct packed {
      logic [FREQ_W-1:0]    low_freq;
      logic [FREQ_W-1:0]    high_freq;
      logic [MASK_BITS-1:0] port_mask;
      logic [PORT_W-1:0]    preferred;
   } bas_entry_type;

   localparam int ENTRY_W = $bits(bas_entry_type);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PICK
   } bas_state_type;

endpackage

// File: rtl/bas_ram.sv
// ----------------------------------------------------------------------------
// Band antenna selector RAM
// Generic simple dual-port RAM with one write port and one read port whose
// data is registered and held while no read is requested.
// ----------------------------------------------------------------------------
module bas_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/band_antenna_selector.sv
// ----------------------------------------------------------------------------
// Band antenna selector
// Band decoder for two radios: picks antenna relays from a band table held in
// one RAM, takes manual relay commands and loads band entries.
// ----------------------------------------------------------------------------
// Every accepted command gives exactly one result beat on the rsp_ ports in the
// cycle after its work ends, and the receiver cannot stall it. Band loads,
// invalid or dropped relay commands, relay OFF commands, unknown command kinds
// and frequency updates with auto mode off finish at once: the result comes
// the cycle after start. A frequency update in auto mode and a relay ON
// command search the band table one entry per cycle through the RAM read port,
// over at most the lesser of bands_in_use and MAX_BANDS entries. busy stays
// high until the result is issued, and a new command may start in the cycle
// that carries the result. After reset the valid bits are cleared, but they
// only mask the preferred port; unloaded ranges and port masks are still used.
module band_antenna_selector #(
   parameter int MAX_BANDS         = 16,
   parameter int PORT_COUNT        = 8,
   parameter int RELAYS_EACH_RADIO = 8,
   parameter int RELAY_TOTAL       = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [bas_pkg::KIND_W-1:0]        req_kind,
   input  logic [bas_pkg::FREQ_W-1:0]        req_frequency,
   input  logic [bas_pkg::RELAY_W-1:0]       req_relay_number,
   input  logic                              req_relay_on,
   input  logic                              req_entry_radio,
   input  logic [bas_pkg::BAND_W-1:0]        req_entry_band,
   input  logic [bas_pkg::FREQ_W-1:0]        req_entry_low_freq,
   input  logic [bas_pkg::FREQ_W-1:0]        req_entry_high_freq,
   input  logic [bas_pkg::MASK_BITS-1:0]     req_entry_port_mask,
   input  logic [bas_pkg::PORT_W-1:0]        req_entry_preferred,
   output logic                              rsp_valid,
   output logic                              rsp_drive,
   output logic [bas_pkg::RELAY_W-1:0]       rsp_out_relay,
   output logic                              rsp_out_radio,
   output logic                              rsp_out_on,
   output logic                              rsp_band_known,
   output logic [bas_pkg::BAND_W-1:0]        rsp_match_band,
   output logic                              rsp_status,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bas_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [bas_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int DEPTH = 2 * MAX_BANDS;
   localparam int AW    = $clog2(DEPTH);
   localparam int BCW   = $clog2(MAX_BANDS + 1);

   bas_pkg::bas_state_type state_ff, state_in;

   logic                              auto_ff;
   logic [bas_pkg::BANDS_CFG_W-1:0]   bands_ff;
   logic [bas_pkg::PORTS_CFG_W-1:0]   ports_ff;
   logic                              single_ff;

   logic [BCW-1:0]                    issue_cnt_ff, issue_cnt_in;
   logic [BCW-1:0]                    chk_band_ff, chk_band_in;
   logic                              pend_ff, pend_in;
   logic                              ent_valid_ff;
   logic [DEPTH-1:0]                  vld_ff;

   logic                              manual_ff;
   logic                              radio_ff;
   logic [bas_pkg::RELAY_W-1:0]       relay_ff;
   logic [bas_pkg::FREQ_W-1:0]        freq_ff;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_drive_ff, rsp_drive_in;
   logic [bas_pkg::RELAY_W-1:0]       rsp_relay_ff, rsp_relay_in;
   logic                              rsp_radio_ff, rsp_radio_in;
   logic                              rsp_on_ff, rsp_on_in;
   logic                              rsp_known_ff, rsp_known_in;
   logic [bas_pkg::BAND_W-1:0]        rsp_band_ff, rsp_band_in;
   logic                              rsp_status_ff, rsp_status_in;

   logic                              accept;
   logic [BCW-1:0]                    n_eff;
   logic                              req_radio;
   logic                              req_relay_bad;
   logic                              req_blocked;
   logic                              load_fits;
   logic [AW-1:0]                     load_addr;
   logic [AW-1:0]                     scan_addr;
   logic [AW-1:0]                     hit_addr;

   logic                              rd_en;
   logic                              wr_en;
   logic [AW-1:0]                     wr_addr;
   bas_pkg::bas_entry_type            wr_entry;
   bas_pkg::bas_entry_type            load_entry;
   logic [bas_pkg::ENTRY_W-1:0]       rd_data;
   bas_pkg::bas_entry_type            rd_entry;
   logic                              hit;

   logic [bas_pkg::MASK_BITS-1:0]     allowed;
   logic [bas_pkg::PORT_W-1:0]        pref_eff;
   logic                              pref_ok;
   logic [bas_pkg::PORT_W-1:0]        low_port;
   logic [bas_pkg::PORT_W-1:0]        target;
   logic                              relay_ok;

   bas_ram #(
      .WIDTH (bas_pkg::ENTRY_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (scan_addr),
      .rd_data (rd_data)
   );

   assign rd_entry  = bas_pkg::bas_entry_type'(rd_data);
   assign accept    = start && (state_ff == bas_pkg::ST_IDLE);
   assign busy      = (state_ff != bas_pkg::ST_IDLE);
   assign csr_ready = 1'b1;

   assign n_eff = (int'(bands_ff) > MAX_BANDS) ? BCW'(MAX_BANDS) : BCW'(bands_ff);

   assign req_radio     = (int'(req_relay_number) > RELAYS_EACH_RADIO);
   assign req_relay_bad = (req_relay_number == '0) || (int'(req_relay_number) > RELAY_TOTAL);
   assign req_blocked   = single_ff && req_radio && req_relay_on;

   assign load_fits = (int'(req_entry_band) < MAX_BANDS);
   assign load_addr = req_entry_radio ? (AW'(MAX_BANDS) + AW'(req_entry_band))
                                      : AW'(req_entry_band);
   assign scan_addr = radio_ff ? (AW'(MAX_BANDS) + AW'(issue_cnt_ff)) : AW'(issue_cnt_ff);
   assign hit_addr  = radio_ff ? (AW'(MAX_BANDS) + AW'(chk_band_ff)) : AW'(chk_band_ff);

   assign load_entry.low_freq  = req_entry_low_freq;
   assign load_entry.high_freq = req_entry_high_freq;
   assign load_entry.port_mask = req_entry_port_mask;
   assign load_entry.preferred = req_entry_preferred;

   assign hit = (freq_ff >= rd_entry.low_freq) && (freq_ff <= rd_entry.high_freq);

   always_comb begin
      allowed  = '0;
      pref_ok  = 1'b0;
      low_port = '0;
      relay_ok = 1'b0;
      pref_eff = ent_valid_ff ? rd_entry.preferred : '0;
      for (int j = 1; j <= bas_pkg::MASK_BITS; j++) begin
         allowed[j-1] = rd_entry.port_mask[j-1] && (j <= int'(ports_ff)) && (j <= PORT_COUNT);
      end
      for (int j = bas_pkg::MASK_BITS; j >= 1; j--) begin
         if (allowed[j-1]) begin
            low_port = bas_pkg::PORT_W'(j);
         end
      end
      for (int j = 1; j <= bas_pkg::MASK_BITS; j++) begin
         if (allowed[j-1] && (int'(pref_eff) == j)) begin
            pref_ok = 1'b1;
         end
         if (allowed[j-1] && (int'(relay_ff) == j)) begin
            relay_ok = 1'b1;
         end
      end
      target = pref_ok ? pref_eff : low_port;
   end

   always_comb begin
      state_in      = state_ff;
      issue_cnt_in  = issue_cnt_ff;
      chk_band_in   = chk_band_ff;
      pend_in       = 1'b0;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = load_addr;
      wr_entry      = load_entry;
      rsp_valid_in  = 1'b0;
      rsp_drive_in  = 1'b0;
      rsp_relay_in  = '0;
      rsp_radio_in  = 1'b0;
      rsp_on_in     = 1'b0;
      rsp_known_in  = 1'b0;
      rsp_band_in   = '0;
      rsp_status_in = 1'b0;
      case (state_ff)
         bas_pkg::ST_IDLE: begin
            issue_cnt_in = '0;
            if (start) begin
               case (req_kind)
                  bas_pkg::KIND_FREQ: begin
                     if (auto_ff) begin
                        state_in = bas_pkg::ST_SCAN;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  bas_pkg::KIND_RELAY: begin
                     if (req_relay_bad) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = 1'b1;
                     end else if (req_blocked) begin
                        rsp_valid_in = 1'b1;
                     end else if (req_relay_on) begin
                        state_in = bas_pkg::ST_SCAN;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_drive_in = 1'b1;
                        rsp_relay_in = req_relay_number;
                        rsp_radio_in = req_radio;
                     end
                  end
                  bas_pkg::KIND_LOAD: begin
                     wr_en        = load_fits;
                     rsp_valid_in = 1'b1;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         bas_pkg::ST_SCAN: begin
            rd_en   = (issue_cnt_ff < n_eff) && !(pend_ff && hit);
            pend_in = rd_en;
            if (rd_en) begin
               issue_cnt_in = issue_cnt_ff + BCW'(1);
               chk_band_in  = issue_cnt_ff;
            end
            if (pend_ff && hit) begin
               state_in = bas_pkg::ST_PICK;
            end else if (issue_cnt_ff >= n_eff) begin
               state_in     = bas_pkg::ST_IDLE;
               rsp_valid_in = 1'b1;
               if (manual_ff) begin
                  rsp_drive_in = 1'b1;
                  rsp_relay_in = relay_ff;
                  rsp_radio_in = radio_ff;
                  rsp_on_in    = 1'b1;
               end
            end
         end
         bas_pkg::ST_PICK: begin
            state_in     = bas_pkg::ST_IDLE;
            rsp_valid_in = 1'b1;
            if (manual_ff) begin
               rsp_drive_in       = 1'b1;
               rsp_relay_in       = relay_ff;
               rsp_radio_in       = radio_ff;
               rsp_on_in          = 1'b1;
               wr_en              = relay_ok;
               wr_addr            = hit_addr;
               wr_entry           = rd_entry;
               wr_entry.preferred = bas_pkg::PORT_W'(relay_ff);
            end else if (target != '0) begin
               rsp_drive_in = 1'b1;
               rsp_relay_in = bas_pkg::RELAY_W'(target);
               rsp_on_in    = 1'b1;
               rsp_known_in = 1'b1;
               rsp_band_in  = bas_pkg::BAND_W'(chk_band_ff);
            end
         end
         default: begin
            state_in = bas_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bas_pkg::ST_IDLE;
         pend_ff      <= 1'b0;
         issue_cnt_ff <= '0;
         chk_band_ff  <= '0;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         auto_ff      <= 1'b1;
         bands_ff     <= '0;
         ports_ff     <= bas_pkg::PORTS_CFG_W'(8);
         single_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         issue_cnt_ff <= issue_cnt_in;
         chk_band_ff  <= chk_band_in;
         rsp_valid_ff <= rsp_valid_in;
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               bas_pkg::CSR_AUTO_MODE: begin
                  auto_ff <= csr_data[0];
               end
               bas_pkg::CSR_BANDS_IN_USE: begin
                  bands_ff <= csr_data[bas_pkg::BANDS_CFG_W-1:0];
               end
               bas_pkg::CSR_PORTS_IN_USE: begin
                  ports_ff <= csr_data[bas_pkg::PORTS_CFG_W-1:0];
               end
               bas_pkg::CSR_SINGLE_A_MODE: begin
                  single_ff <= csr_data[0];
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         manual_ff <= (req_kind == bas_pkg::KIND_RELAY);
         radio_ff  <= (req_kind == bas_pkg::KIND_RELAY) && req_radio;
         relay_ff  <= req_relay_number;
         freq_ff   <= req_frequency;
      end
      if (rd_en) begin
         ent_valid_ff <= vld_ff[scan_addr];
      end
      rsp_drive_ff  <= rsp_drive_in;
      rsp_relay_ff  <= rsp_relay_in;
      rsp_radio_ff  <= rsp_radio_in;
      rsp_on_ff     <= rsp_on_in;
      rsp_known_ff  <= rsp_known_in;
      rsp_band_ff   <= rsp_band_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_drive      = rsp_drive_ff;
   assign rsp_out_relay  = rsp_relay_ff;
   assign rsp_out_radio  = rsp_radio_ff;
   assign rsp_out_on     = rsp_on_ff;
   assign rsp_band_known = rsp_known_ff;
   assign rsp_match_band = rsp_band_ff;
   assign rsp_status     = rsp_status_ff;

endmodule
